/* design/bpr_pkg.sv */
// ----------------------------------------------------------------------------
// bpr_pkg
// shared types and constants of the bmp pixel repacker
// ----------------------------------------------------------------------------
package bpr_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam int unsigned COL_W     = 16;
    localparam int unsigned ROW_CNT_W = 18;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LEVEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_BYTE_PAL = 2'd3;

    // depth codes
    localparam logic [1:0] DEPTH_1BPP  = 2'd0;
    localparam logic [1:0] DEPTH_4BPP  = 2'd1;
    localparam logic [1:0] DEPTH_8BPP  = 2'd2;
    localparam logic [1:0] DEPTH_24BPP = 2'd3;

    // input actions
    localparam logic ACT_PALETTE = 1'b0;
    localparam logic ACT_PIXEL   = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // command kinds
    localparam logic [1:0] CMD_PAL = 2'd0;
    localparam logic [1:0] CMD_IDX = 2'd1;
    localparam logic [1:0] CMD_RGB = 2'd2;

    typedef struct packed {
        logic [1:0]       depth_mode;
        logic [COL_W-1:0] image_width;
        logic [7:0]       alpha_level;
        logic             four_byte_palette;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] npix;
        logic [1:0] pad;
        logic       row_done;
    } cmd_t;

endpackage

/* design/bpr_in_if.sv */
// ----------------------------------------------------------------------------
// bpr_in_if
// input channel: palette and pixel bytes
// ----------------------------------------------------------------------------
interface bpr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source
    (
        output valid,
        output action,
        output data_byte,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  action,
        input  data_byte,
        output ready
    );
endinterface

/* design/bpr_out_if.sv */
// ----------------------------------------------------------------------------
// bpr_out_if
// output channel: converted buffer bytes
// ----------------------------------------------------------------------------
interface bpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       row_end;

    modport source
    (
        output valid,
        output out_byte,
        output last_of_run,
        output row_end,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  out_byte,
        input  last_of_run,
        input  row_end,
        output ready
    );
endinterface

/* design/bmp_pixel_repacker_top.sv */
// ----------------------------------------------------------------------------
// bmp_pixel_repacker_top
// converts bmp palette and pixel-row bytes into lossless bitmap buffer bytes
// ----------------------------------------------------------------------------
// pixels carries one input byte per transfer: action selects palette byte or
// pixel data byte. buffer carries one converted byte per transfer, with
// last_of_run on the final byte caused by an input byte and row_end on the
// last byte of a pixel row. registers are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle, and
// the block itself has no check for this. an input byte that produces output
// is first pushed into the command queue, and its first byte then goes into
// the output register before it is valid on buffer. the emitter gives one
// byte per cycle while buffer ready is high. a palette entry gives three or
// four bytes, a 24-bit pixel four, and a 1bpp data byte up to eight, plus up
// to three row pad bytes. bytes with no output (row padding, held color
// bytes) push no command. a command queue of QUEUE_DEPTH entries lets input
// transfers continue while the emitter works through earlier bytes.
// reset clears all position counters, the queue and the output valid flag and
// loads the register defaults (8bpp, width 1, opaque, four-byte palette).
// when the receiver stalls the output byte holds, the queue fills and pixels
// ready drops once it is full.
// ----------------------------------------------------------------------------
module bmp_pixel_repacker_top #(
    parameter int unsigned QUEUE_DEPTH = bpr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bpr_in_if.sink                          pixels,
    bpr_out_if.source                       buffer,
    input  logic                            cfg_we,
    input  logic [bpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpr_pkg::CFG_DAT_W-1:0]   cfg_data
);
    bpr_pkg::cfg_t cfg_reg, cfg_next;
    bpr_pkg::cmd_t push_cmd;
    bpr_pkg::cmd_t head_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bpr_pkg::REG_DEPTH_MODE:    cfg_next.depth_mode = cfg_data[1:0];
                bpr_pkg::REG_IMAGE_WIDTH:   cfg_next.image_width = cfg_data;
                bpr_pkg::REG_ALPHA_LEVEL:   cfg_next.alpha_level = cfg_data[7:0];
                bpr_pkg::REG_FOUR_BYTE_PAL: cfg_next.four_byte_palette = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_mode        <= bpr_pkg::DEPTH_8BPP;
            cfg_reg.image_width       <= 16'd1;
            cfg_reg.alpha_level       <= bpr_pkg::ALPHA_OPAQUE;
            cfg_reg.four_byte_palette <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .push   (push),
        .cmd    (push_cmd)
    );

    bpr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_cmd),
        .full  (q_full),
        .pop   (pop),
        .dout  (head_cmd),
        .empty (q_empty)
    );

    bpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (!q_empty),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .buffer    (buffer)
    );

    // a row can only end on the final byte of an input byte
    a_row_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        buffer.valid && buffer.row_end |-> buffer.last_of_run)
        else $error("row_end without last_of_run");

    // the emitter never retires a command from an empty queue
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("command pop from empty queue");

    // no output byte appears without a queued command
    a_no_invented_output: assert property (@(posedge clk) disable iff (!rst_n)
        !buffer.valid && q_empty |=> !buffer.valid)
        else $error("output valid with no queued command");
endmodule

/* design/bpr_fifo.sv */
// ----------------------------------------------------------------------------
// bpr_fifo
// command queue between the classifier and the byte emitter
// ----------------------------------------------------------------------------
module bpr_fifo #(
    parameter int unsigned DEPTH = bpr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bpr_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output bpr_pkg::cmd_t dout,
    output logic          empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    bpr_pkg::cmd_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end
endmodule

/* design/bpr_front.sv */
// ----------------------------------------------------------------------------
// bpr_front
// accepts input bytes, tracks palette and row position, issues commands
// ----------------------------------------------------------------------------
module bpr_front (
    input  logic          clk,
    input  logic          rst_n,
    bpr_in_if.sink        pixels,
    input  bpr_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          push,
    output bpr_pkg::cmd_t cmd
);
    localparam int unsigned CW = bpr_pkg::COL_W;
    localparam int unsigned RW = bpr_pkg::ROW_CNT_W;

    logic [1:0]    pal_pos_reg, pal_pos_next;
    logic [7:0]    blue_reg, blue_next;
    logic [7:0]    green_reg, green_next;
    logic [1:0]    pix_pos_reg, pix_pos_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;

    logic          accept;
    logic          col_lt;
    logic [CW-1:0] remaining;
    logic [3:0]    per;
    logic          fits;
    logic [3:0]    npix;
    logic [21:0]   row_bits;
    logic [21:0]   row_bits_rnd;
    logic [RW:0]   in_row;
    logic [RW-1:0] row_cnt_inc;

    assign pixels.ready = !q_full;
    assign accept       = pixels.valid && pixels.ready;

    assign col_lt    = col_reg < cfg.image_width;
    assign remaining = cfg.image_width - col_reg;

    always_comb
    begin
        case (cfg.depth_mode)
            bpr_pkg::DEPTH_1BPP: per = 4'd8;
            bpr_pkg::DEPTH_4BPP: per = 4'd2;
            default:             per = 4'd1;
        endcase
    end

    assign fits = remaining <= {{(CW-4){1'b0}}, per};
    assign npix = fits ? remaining[3:0] : per;

    // input row length in bytes, rounded up to whole words
    always_comb
    begin
        case (cfg.depth_mode)
            bpr_pkg::DEPTH_1BPP: row_bits = {6'd0, cfg.image_width};
            bpr_pkg::DEPTH_4BPP: row_bits = {4'd0, cfg.image_width, 2'b00};
            bpr_pkg::DEPTH_8BPP: row_bits = {3'd0, cfg.image_width, 3'b000};
            default:
            begin
                row_bits = {2'd0, cfg.image_width, 4'b0000}
                         + {3'd0, cfg.image_width, 3'b000};
            end
        endcase
    end

    assign row_bits_rnd = row_bits + 22'd31;
    assign in_row       = {row_bits_rnd[21:5], 2'b00};
    assign row_cnt_inc  = row_cnt_reg + 1'b1;

    always_comb
    begin
        pal_pos_next = pal_pos_reg;
        blue_next    = blue_reg;
        green_next   = green_reg;
        pix_pos_next = pix_pos_reg;
        col_next     = col_reg;
        row_cnt_next = row_cnt_reg;
        push         = 1'b0;
        cmd          = '0;
        cmd.data     = pixels.data_byte;
        cmd.green    = green_reg;
        cmd.blue     = blue_reg;

        if (accept)
        begin
            if (pixels.action == bpr_pkg::ACT_PALETTE)
            begin
                case (pal_pos_reg)
                    2'd0: blue_next = pixels.data_byte;
                    2'd1: green_next = pixels.data_byte;
                    2'd2:
                    begin
                        push     = 1'b1;
                        cmd.kind = bpr_pkg::CMD_PAL;
                    end
                    default: ;
                endcase
                if (pal_pos_reg == 2'd3 || (pal_pos_reg == 2'd2 && !cfg.four_byte_palette))
                begin
                    pal_pos_next = 2'd0;
                end
                else
                begin
                    pal_pos_next = pal_pos_reg + 1'b1;
                end
            end
            else
            begin
                if (cfg.depth_mode != bpr_pkg::DEPTH_24BPP)
                begin
                    if (col_lt)
                    begin
                        push         = 1'b1;
                        cmd.kind     = bpr_pkg::CMD_IDX;
                        cmd.npix     = npix;
                        cmd.row_done = fits;
                        cmd.pad      = fits ? 2'd0 - cfg.image_width[1:0] : 2'd0;
                        col_next     = col_reg + {{(CW-4){1'b0}}, npix};
                    end
                end
                else if (col_lt)
                begin
                    case (pix_pos_reg)
                        2'd0:
                        begin
                            blue_next    = pixels.data_byte;
                            pix_pos_next = 2'd1;
                        end
                        2'd1:
                        begin
                            green_next   = pixels.data_byte;
                            pix_pos_next = 2'd2;
                        end
                        default:
                        begin
                            push         = 1'b1;
                            cmd.kind     = bpr_pkg::CMD_RGB;
                            cmd.row_done = (col_reg + 1'b1) == cfg.image_width;
                            pix_pos_next = 2'd0;
                            col_next     = col_reg + 1'b1;
                        end
                    endcase
                end

                row_cnt_next = row_cnt_inc;
                if ({1'b0, row_cnt_inc} >= in_row)
                begin
                    row_cnt_next = '0;
                    col_next     = '0;
                    pix_pos_next = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_pos_reg <= '0;
            blue_reg    <= '0;
            green_reg   <= '0;
            pix_pos_reg <= '0;
            col_reg     <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            pal_pos_reg <= pal_pos_next;
            blue_reg    <= blue_next;
            green_reg   <= green_next;
            pix_pos_reg <= pix_pos_next;
            col_reg     <= col_next;
            row_cnt_reg <= row_cnt_next;
        end
    end
endmodule

/* design/bpr_back.sv */
// ----------------------------------------------------------------------------
// bpr_back
// expands one command into buffer bytes, one byte per cycle while buffer ready is high
// ----------------------------------------------------------------------------
module bpr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  bpr_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    input  bpr_pkg::cmd_t cmd,
    output logic          cmd_pop,
    bpr_out_if.source     buffer
);
    logic [3:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        row_end_reg, row_end_next;

    logic        alpha_en;
    logic [3:0]  cnt;
    logic        last;
    logic        advance;
    logic        use_shade;
    logic [7:0]  ch;
    logic [7:0]  raw;
    logic [15:0] product;
    logic [7:0]  shaded;

    assign alpha_en = cfg.alpha_level != bpr_pkg::ALPHA_OPAQUE;

    always_comb
    begin
        case (cmd.kind)
            bpr_pkg::CMD_PAL: cnt = alpha_en ? 4'd4 : 4'd3;
            bpr_pkg::CMD_RGB: cnt = 4'd4;
            default:          cnt = cmd.npix + {2'b00, cmd.pad};
        endcase
    end

    assign last = step_reg == (cnt - 4'd1);

    // byte selection for the current step
    always_comb
    begin
        use_shade = 1'b0;
        ch        = cmd.data;
        raw       = 8'd0;
        case (cmd.kind)
            bpr_pkg::CMD_PAL:
            begin
                use_shade = 1'b1;
                case (step_reg[1:0])
                    2'd0: ch = cmd.data;
                    2'd1: ch = cmd.green;
                    2'd2: ch = cmd.blue;
                    default:
                    begin
                        use_shade = 1'b0;
                        raw       = cfg.alpha_level;
                    end
                endcase
            end
            bpr_pkg::CMD_RGB:
            begin
                use_shade = 1'b1;
                case (step_reg[1:0])
                    2'd0:
                    begin
                        use_shade = 1'b0;
                        raw       = alpha_en ? cfg.alpha_level : 8'd0;
                    end
                    2'd1: ch = cmd.data;
                    2'd2: ch = cmd.green;
                    default: ch = cmd.blue;
                endcase
            end
            default:
            begin
                if (step_reg < cmd.npix)
                begin
                    case (cfg.depth_mode)
                        bpr_pkg::DEPTH_1BPP: raw = {7'd0, cmd.data[3'd7 - step_reg[2:0]]};
                        bpr_pkg::DEPTH_4BPP:
                        begin
                            raw = step_reg[0] ? {4'd0, cmd.data[3:0]} : {4'd0, cmd.data[7:4]};
                        end
                        default: raw = cmd.data;
                    endcase
                end
            end
        endcase
    end

    assign product = {8'd0, ch} * {8'd0, cfg.alpha_level};
    assign shaded  = alpha_en ? product[15:8] : ch;

    assign advance = !valid_reg || buffer.ready;
    assign cmd_pop = advance && cmd_valid && last;

    always_comb
    begin
        step_next    = step_reg;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        row_end_next = row_end_reg;
        if (advance)
        begin
            valid_next = cmd_valid;
            if (cmd_valid)
            begin
                byte_next    = use_shade ? shaded : raw;
                last_next    = last;
                row_end_next = last && cmd.row_done;
                step_next    = last ? 4'd0 : step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        row_end_reg <= row_end_next;
    end

    assign buffer.valid       = valid_reg;
    assign buffer.out_byte    = byte_reg;
    assign buffer.last_of_run = last_reg;
    assign buffer.row_end     = row_end_reg;
endmodule
